// ----- src/stomp_pkg.sv -----
// ----------------------------------------------------------------------------
// STOMP deframer package
// Shared types and constants for the STOMP frame deframer.
// ----------------------------------------------------------------------------
package stomp_pkg;

   localparam int unsigned LENGTH_WIDTH_DEFAULT = 24;
   localparam logic [23:0] MAX_LEN_RESET = 24'd8388608;

   localparam logic [3:0] KIND_HEARTBEAT = 4'd0;
   localparam logic [3:0] KIND_CMD_BYTE  = 4'd1;
   localparam logic [3:0] KIND_CMD_END   = 4'd2;
   localparam logic [3:0] KIND_KEY_BYTE  = 4'd3;
   localparam logic [3:0] KIND_VAL_BYTE  = 4'd4;
   localparam logic [3:0] KIND_LINE_END  = 4'd5;
   localparam logic [3:0] KIND_BODY_BYTE = 4'd6;
   localparam logic [3:0] KIND_FRAME_END = 4'd7;
   localparam logic [3:0] KIND_ERROR     = 4'd8;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_NO_CMD    = 4'd1;
   localparam logic [3:0] ERR_NUL_CMD   = 4'd2;
   localparam logic [3:0] ERR_NUL_HDR   = 4'd3;
   localparam logic [3:0] ERR_NO_COLON  = 4'd4;
   localparam logic [3:0] ERR_ESCAPE    = 4'd5;
   localparam logic [3:0] ERR_LEN_BAD   = 4'd6;
   localparam logic [3:0] ERR_LEN_LARGE = 4'd7;
   localparam logic [3:0] ERR_FRAME     = 4'd8;

   localparam logic [0:0] CSR_MAX_CONTENT_LENGTH = 1'b0;
   localparam logic [0:0] CSR_MAX_FRAME_BYTES    = 1'b1;

   localparam logic [3:0] MISMATCH = 4'd15;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_CMD  = 5'b00010,
      PH_KEY  = 5'b00100,
      PH_VAL  = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       chunk_last;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] out_byte;
      logic [3:0] error_code;
      logic       last_result;
   } rsp_type;

   function automatic logic [7:0] cmd_pat(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0: c = "C";
         4'd1: c = "O";
         4'd2: c = "N";
         4'd3: c = "N";
         4'd4: c = "E";
         4'd5: c = "C";
         4'd6: c = "T";
         4'd7: c = "E";
         4'd8: c = "D";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] key_pat(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0: c = "c";
         4'd1: c = "o";
         4'd2: c = "n";
         4'd3: c = "t";
         4'd4: c = "e";
         4'd5: c = "n";
         4'd6: c = "t";
         4'd7: c = "-";
         4'd8: c = "l";
         4'd9: c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

// ----- src/stomp_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// STOMP frame deframer
// Turns STOMP wire bytes into tagged command, header and body transactions.
// ----------------------------------------------------------------------------
// Output: a byte's results are registered and appear in the cycle after the byte is accepted.
// Throughput: 1 byte per cycle while the output is not stalled, set by the combinational parse step;
//   a byte that makes two results (held CR then data) holds input while both results are pending.
// Reset: synchronous, active high; parser idle between frames, limits at 8 MiB.
// ----------------------------------------------------------------------------
module stomp_frame_deframer #(
   parameter int unsigned LENGTH_WIDTH = stomp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  stomp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stomp_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam int unsigned LW = LENGTH_WIDTH;
   localparam int unsigned AW = LW + 4;
   localparam int unsigned CW = (LW > 24) ? LW : 24;

   // Configuration registers
   logic [23:0] max_clen_ff, max_frame_ff;

   // Parser state
   stomp_pkg::phase_type phase_ff, phase_in;
   logic        held_cr_ff, held_cr_in;
   logic        held_bs_ff, held_bs_in;
   logic [3:0]  cmd_pos_ff, cmd_pos_in;
   logic        esc_ff, esc_in;
   logic [3:0]  key_pos_ff, key_pos_in;
   logic        len_seen_ff, len_seen_in;
   logic [LW-1:0] len_acc_ff, len_acc_in;
   logic [LW-1:0] body_rem_ff, body_rem_in;
   logic [24:0] fcount_ff, fcount_in;
   logic        discard_ff, discard_in;
   logic        line_st_ff, line_st_in;
   logic        bad_esc_ff, bad_esc_in;
   logic        cand_ff, cand_in;
   logic        lbad_ff, lbad_in;
   logic        ldig_ff, ldig_in;
   logic        lover_ff, lover_in;

   // Two-entry result buffer
   stomp_pkg::rsp_type res0_ff, res1_ff, r0, r1;
   logic [1:0]  cnt_ff;
   logic [1:0]  n;
   logic        accept, pop;
   logic        cur_last;
   logic [7:0]  b;

   assign b        = req_data.in_byte;
   assign cur_last = req_data.chunk_last;
   assign pop      = rsp_valid && !rsp_stall;
   // accept when the buffer drains this cycle (or is empty)
   assign req_stall = (cnt_ff == 2'd2) || (cnt_ff == 2'd1 && !pop);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = res0_ff;

   // Per-byte parse step
   always_comb begin
      logic [AW-1:0] v;
      logic [24:0]   fc;
      logic [1:0]    inc;
      logic          done;
      logic          data_ok;
      logic [7:0]    d;
      logic          have_d;
      logic          fail;
      logic [3:0]    fcode;
      logic          cr_emit;
      v = '0; fc = '0; inc = '0; done = 1'b0; data_ok = 1'b0; d = '0;
      have_d = 1'b0; fail = 1'b0; fcode = stomp_pkg::ERR_NONE; cr_emit = 1'b0;
      phase_in = phase_ff; held_cr_in = held_cr_ff; held_bs_in = held_bs_ff;
      cmd_pos_in = cmd_pos_ff; esc_in = esc_ff; key_pos_in = key_pos_ff;
      len_seen_in = len_seen_ff; len_acc_in = len_acc_ff; body_rem_in = body_rem_ff;
      fcount_in = fcount_ff; discard_in = discard_ff; line_st_in = line_st_ff;
      bad_esc_in = bad_esc_ff; cand_in = cand_ff; lbad_in = lbad_ff;
      ldig_in = ldig_ff; lover_in = lover_ff;
      r0 = '0; r1 = '0; n = 2'd0;

      if (discard_ff) begin
         if (cur_last) discard_in = 1'b0;
         done = 1'b1;
      end

      // frame size check
      if (!done) begin
         if (phase_ff != stomp_pkg::PH_IDLE) inc = 2'd1;
         else if (b != 8'h0A && b != 8'h00 && (held_cr_ff || b != 8'h0D))
            inc = held_cr_ff ? 2'd2 : 2'd1;
         fc = fcount_ff + {23'd0, inc};
         fcount_in = fc;
         if (inc != 2'd0 && fc > {1'b0, max_frame_ff}) begin
            fail = 1'b1; fcode = stomp_pkg::ERR_FRAME; done = 1'b1;
         end
      end

      if (!done) begin
         case (phase_ff)
            stomp_pkg::PH_IDLE: begin
               if (b == 8'h0A) begin
                  held_cr_in = 1'b0;
                  r0.kind = stomp_pkg::KIND_HEARTBEAT; n = 2'd1;
               end else if (b == 8'h00) begin
                  fail = 1'b1;
                  fcode = held_cr_ff ? stomp_pkg::ERR_NUL_CMD : stomp_pkg::ERR_NO_CMD;
               end else if (b == 8'h0D && !held_cr_ff) begin
                  held_cr_in = 1'b1;
               end else begin
                  // start of command; a held CR is the first command byte
                  phase_in = stomp_pkg::PH_CMD;
                  cmd_pos_in = 4'd0;
                  if (held_cr_ff) begin
                     r0.kind = stomp_pkg::KIND_CMD_BYTE; r0.out_byte = 8'h0D;
                     n = 2'd1; cmd_pos_in = stomp_pkg::MISMATCH;
                     held_cr_in = (b == 8'h0D);
                     if (b != 8'h0D && b != 8'h0A) begin
                        r1.kind = stomp_pkg::KIND_CMD_BYTE; r1.out_byte = b;
                        n = 2'd2;
                     end else if (b == 8'h0A) begin
                        r1.kind = stomp_pkg::KIND_CMD_END; n = 2'd2;
                        held_cr_in = 1'b0; esc_in = 1'b1;
                        phase_in = stomp_pkg::PH_KEY;
                        held_bs_in = 1'b0; key_pos_in = 4'd0; line_st_in = 1'b0;
                        bad_esc_in = 1'b0; cand_in = 1'b0; lbad_in = 1'b0;
                        ldig_in = 1'b0; lover_in = 1'b0;
                     end
                  end else begin
                     r0.kind = stomp_pkg::KIND_CMD_BYTE; r0.out_byte = b; n = 2'd1;
                     cmd_pos_in = (b == stomp_pkg::cmd_pat(4'd0)) ? 4'd1
                                                                   : stomp_pkg::MISMATCH;
                  end
               end
            end
            stomp_pkg::PH_CMD: begin
               if (b == 8'h00) begin
                  fail = 1'b1; fcode = stomp_pkg::ERR_NUL_CMD;
               end else if (b == 8'h0A) begin
                  held_cr_in = 1'b0;
                  r0.kind = stomp_pkg::KIND_CMD_END; n = 2'd1;
                  esc_in = !(cmd_pos_ff == 4'd7 || cmd_pos_ff == 4'd9);
                  phase_in = stomp_pkg::PH_KEY;
                  held_bs_in = 1'b0; key_pos_in = 4'd0; line_st_in = 1'b0;
                  bad_esc_in = 1'b0; cand_in = 1'b0; lbad_in = 1'b0;
                  ldig_in = 1'b0; lover_in = 1'b0;
               end else begin
                  logic [3:0] p;
                  p = cmd_pos_ff;
                  if (held_cr_ff) begin
                     r0.kind = stomp_pkg::KIND_CMD_BYTE; r0.out_byte = 8'h0D; n = 2'd1;
                     p = stomp_pkg::MISMATCH;
                  end
                  held_cr_in = (b == 8'h0D);
                  if (b != 8'h0D) begin
                     if (n == 2'd1) begin
                        r1.kind = stomp_pkg::KIND_CMD_BYTE; r1.out_byte = b;
                     end else begin
                        r0.kind = stomp_pkg::KIND_CMD_BYTE; r0.out_byte = b;
                     end
                     n = n + 2'd1;
                     p = (p < 4'd9 && b == stomp_pkg::cmd_pat(p)) ? p + 4'd1
                                                                   : stomp_pkg::MISMATCH;
                  end
                  cmd_pos_in = p;
               end
            end
            stomp_pkg::PH_KEY, stomp_pkg::PH_VAL: begin
               if (b == 8'h00) begin
                  fail = 1'b1; fcode = stomp_pkg::ERR_NUL_HDR;
               end else if (b == 8'h0A) begin
                  held_cr_in = 1'b0;
                  // line end checks
                  if (!line_st_ff) begin
                     r0.kind = stomp_pkg::KIND_LINE_END; n = 2'd1;
                     phase_in = stomp_pkg::PH_BODY;
                  end else if (phase_ff == stomp_pkg::PH_KEY) begin
                     fail = 1'b1; fcode = stomp_pkg::ERR_NO_COLON;
                  end else if (bad_esc_ff || held_bs_ff) begin
                     fail = 1'b1; fcode = stomp_pkg::ERR_ESCAPE;
                  end else if (cand_ff && (lbad_ff || !ldig_ff)) begin
                     fail = 1'b1; fcode = stomp_pkg::ERR_LEN_BAD;
                  end else if (cand_ff && (lover_ff ||
                               CW'(len_acc_ff) > CW'(max_clen_ff))) begin
                     fail = 1'b1; fcode = stomp_pkg::ERR_LEN_LARGE;
                  end else begin
                     if (cand_ff) begin
                        len_seen_in = 1'b1; body_rem_in = len_acc_ff;
                     end
                     r0.kind = stomp_pkg::KIND_LINE_END; n = 2'd1;
                     phase_in = stomp_pkg::PH_KEY;
                  end
                  if (!fail) begin
                     held_bs_in = 1'b0; key_pos_in = 4'd0; line_st_in = 1'b0;
                     bad_esc_in = 1'b0; cand_in = 1'b0; lbad_in = 1'b0;
                     ldig_in = 1'b0; lover_in = 1'b0;
                  end
               end else begin
                  // up to two content bytes: held CR, then this byte
                  stomp_pkg::phase_type ph;
                  logic bs, be, cd, lb, ld, lo;
                  logic [3:0] kp;
                  logic [LW-1:0] acc;
                  logic [7:0] c;
                  ph = phase_ff; bs = held_bs_ff; be = bad_esc_ff; cd = cand_ff;
                  lb = lbad_ff; ld = ldig_ff; lo = lover_ff; kp = key_pos_ff;
                  acc = len_acc_ff;
                  held_cr_in = (b == 8'h0D);
                  for (int i = 0; i < 2; i++) begin
                     logic act;
                     act = (i == 0) ? held_cr_ff : (b != 8'h0D);
                     c = (i == 0) ? 8'h0D : b;
                     have_d = 1'b0; d = c;
                     if (act) begin
                        line_st_in = 1'b1;
                        if (ph == stomp_pkg::PH_KEY && c == ":") begin
                           if (bs) be = 1'b1;
                           bs = 1'b0;
                           cd = (kp == 4'd14) && !len_seen_ff;
                           if (cd) acc = '0;
                           ph = stomp_pkg::PH_VAL;
                        end else if (!esc_ff) begin
                           have_d = 1'b1;
                        end else if (bs) begin
                           bs = 1'b0;
                           case (c)
                              "\\": begin have_d = 1'b1; d = 8'h5C; end
                              "n": begin have_d = 1'b1; d = 8'h0A; end
                              "r": begin have_d = 1'b1; d = 8'h0D; end
                              "c": begin have_d = 1'b1; d = ":"; end
                              default: be = 1'b1;
                           endcase
                        end else if (c == 8'h5C) begin
                           bs = 1'b1;
                        end else begin
                           have_d = 1'b1;
                        end
                     end
                     if (have_d) begin
                        stomp_pkg::rsp_type r;
                        r = '0; r.out_byte = d;
                        if (ph == stomp_pkg::PH_KEY) begin
                           r.kind = stomp_pkg::KIND_KEY_BYTE;
                           kp = (kp < 4'd14 && d == stomp_pkg::key_pat(kp)) ? kp + 4'd1
                                                                  : stomp_pkg::MISMATCH;
                        end else begin
                           r.kind = stomp_pkg::KIND_VAL_BYTE;
                           if (cd) begin
                              if (d < "0" || d > "9") lb = 1'b1;
                              else begin
                                 ld = 1'b1;
                                 if (!lo) begin
                                    v = {4'd0, acc} * AW'(10) + AW'(d - "0");
                                    if (v[AW-1:LW] != '0) lo = 1'b1;
                                    else acc = v[LW-1:0];
                                 end
                              end
                           end
                        end
                        if (n == 2'd0) r0 = r; else r1 = r;
                        n = n + 2'd1;
                     end
                  end
                  phase_in = ph; held_bs_in = bs; bad_esc_in = be; cand_in = cd;
                  lbad_in = lb; ldig_in = ld; lover_in = lo; key_pos_in = kp;
                  len_acc_in = acc;
               end
            end
            default: begin
               if (len_seen_ff && body_rem_ff != '0) begin
                  r0.kind = stomp_pkg::KIND_BODY_BYTE; r0.out_byte = b; n = 2'd1;
                  body_rem_in = body_rem_ff - LW'(1);
               end else if (b == 8'h00) begin
                  r0.kind = stomp_pkg::KIND_FRAME_END; n = 2'd1;
                  done = 1'b1;
               end else if (len_seen_ff) begin
                  fail = 1'b1; fcode = stomp_pkg::ERR_FRAME;
               end else begin
                  r0.kind = stomp_pkg::KIND_BODY_BYTE; r0.out_byte = b; n = 2'd1;
               end
            end
         endcase
         cr_emit = 1'b0;
      end

      // frame end or error: clear frame state
      if (fail) begin
         stomp_pkg::rsp_type r;
         r = '0; r.kind = stomp_pkg::KIND_ERROR; r.error_code = fcode;
         if (n == 2'd0) r0 = r; else r1 = r;
         n = n + 2'd1;
         discard_in = !cur_last;
      end
      if (fail || (done && !discard_ff && !cr_emit && n != 2'd0)) begin
         phase_in = stomp_pkg::PH_IDLE; held_cr_in = 1'b0; cmd_pos_in = 4'd0;
         esc_in = 1'b1; len_seen_in = 1'b0; len_acc_in = '0; body_rem_in = '0;
         fcount_in = '0; line_st_in = 1'b0; bad_esc_in = 1'b0; cand_in = 1'b0;
         lbad_in = 1'b0; ldig_in = 1'b0; lover_in = 1'b0; held_bs_in = 1'b0;
         key_pos_in = 4'd0;
      end
      if (n == 2'd1) r0.last_result = 1'b1;
      if (n == 2'd2) r1.last_result = 1'b1;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_clen_ff  <= stomp_pkg::MAX_LEN_RESET;
         max_frame_ff <= stomp_pkg::MAX_LEN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            stomp_pkg::CSR_MAX_CONTENT_LENGTH: max_clen_ff <= csr_wdata;
            stomp_pkg::CSR_MAX_FRAME_BYTES:    max_frame_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance parser state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stomp_pkg::PH_IDLE; held_cr_ff <= 1'b0; held_bs_ff <= 1'b0;
         cmd_pos_ff <= 4'd0; esc_ff <= 1'b1; key_pos_ff <= 4'd0;
         len_seen_ff <= 1'b0; len_acc_ff <= '0; body_rem_ff <= '0;
         fcount_ff <= '0; discard_ff <= 1'b0; line_st_ff <= 1'b0;
         bad_esc_ff <= 1'b0; cand_ff <= 1'b0; lbad_ff <= 1'b0;
         ldig_ff <= 1'b0; lover_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in; held_cr_ff <= held_cr_in; held_bs_ff <= held_bs_in;
         cmd_pos_ff <= cmd_pos_in; esc_ff <= esc_in; key_pos_ff <= key_pos_in;
         len_seen_ff <= len_seen_in; len_acc_ff <= len_acc_in;
         body_rem_ff <= body_rem_in; fcount_ff <= fcount_in;
         discard_ff <= discard_in; line_st_ff <= line_st_in;
         bad_esc_ff <= bad_esc_in; cand_ff <= cand_in; lbad_ff <= lbad_in;
         ldig_ff <= ldig_in; lover_ff <= lover_in;
      end
   end

   // Result buffer: load on accept, shift on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (accept) begin
         cnt_ff <= n;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res0_ff <= r0;
         res1_ff <= r1;
      end else if (pop) begin
         res0_ff <= res1_ff;
      end
   end

endmodule

// ----- src/stomp_checker.sv -----
// ----------------------------------------------------------------------------
// STOMP deframer checker
// Port-level checks on the deframer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module stomp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input stomp_pkg::rsp_type rsp_data
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Error results carry a code and no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == stomp_pkg::KIND_ERROR |->
      rsp_data.error_code != stomp_pkg::ERR_NONE && rsp_data.out_byte == 8'd0)
      else $error("malformed error result");

   // Non-error results carry no code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != stomp_pkg::KIND_ERROR |->
      rsp_data.error_code == stomp_pkg::ERR_NONE)
      else $error("code on non-error result");

   // Stall input while a stalled result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // Empty output never stalls input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no pending result");

endmodule

bind stomp_frame_deframer stomp_checker u_stomp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STOMP frame deframer testbench
// Sends directed and random STOMP byte streams with random idling on both
// sides. Every accepted byte runs through a local parser model, and each
// result transaction is checked field by field against the oldest expected
// result.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [7:0] LF    = 8'h0A;
   localparam logic [7:0] CR    = 8'h0D;
   localparam logic [7:0] NUL   = 8'h00;
   localparam logic [7:0] BSL   = 8'h5C;
   localparam logic [7:0] COLON = 8'h3A;
   localparam logic [23:0] LEN_MAX = 24'hFFFFFF;
   localparam int STALL_LIMIT = 4000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   stomp_pkg::req_type  req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   stomp_pkg::rsp_type  rsp_data;
   logic                csr_write = 1'b0;
   logic [0:0]          csr_index = '0;
   logic [23:0]         csr_wdata = '0;

   stomp_frame_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expected results
   stomp_pkg::req_type wire_q[$];
   stomp_pkg::rsp_type parsed_q[$];
   stomp_pkg::rsp_type byte_res_q[$];
   int      send_idle = 0;
   int      recv_idle = 0;
   int      mismatches = 0;
   int      bytes_sent = 0;
   int      results_seen = 0;
   int      errors_seen = 0;
   int      quiet_cycles = 0;

   // parser model state
   logic [23:0] lim_content;
   logic [23:0] lim_frame;
   stomp_pkg::phase_type ph;
   logic        held_cr, held_bs, esc_mode, len_seen, discarding, cur_last;
   logic [3:0]  cmd_pos, key_pos;
   logic [23:0] len_acc, body_left;
   int unsigned frame_cnt;
   logic        line_started, bad_esc, len_cand, len_bad, len_digit, len_over;

   function automatic void put(logic [3:0] k, logic [7:0] b, logic [3:0] c);
      stomp_pkg::rsp_type r;
      r.kind = k;
      r.out_byte = b;
      r.error_code = c;
      r.last_result = 1'b0;
      byte_res_q.push_back(r);
   endfunction

   function automatic void line_clear();
      line_started = 1'b0; bad_esc = 1'b0; len_cand = 1'b0;
      len_bad = 1'b0; len_digit = 1'b0; len_over = 1'b0;
      held_bs = 1'b0; key_pos = 4'd0;
   endfunction

   function automatic void frame_clear();
      ph = stomp_pkg::PH_IDLE; held_cr = 1'b0; cmd_pos = 4'd0; esc_mode = 1'b1;
      len_seen = 1'b0; len_acc = '0; body_left = '0; frame_cnt = 0;
      line_clear();
   endfunction

   function automatic void flag_error(logic [3:0] code);
      put(stomp_pkg::KIND_ERROR, 8'd0, code);
      frame_clear();
      discarding = !cur_last;
   endfunction

   function automatic void cmd_char(logic [7:0] c);
      logic [7:0] pat;
      case (cmd_pos)
         4'd0, 4'd5: pat = "C";
         4'd1: pat = "O";
         4'd2, 4'd3: pat = "N";
         4'd4, 4'd7: pat = "E";
         4'd6: pat = "T";
         4'd8: pat = "D";
         default: pat = 8'd0;
      endcase
      put(stomp_pkg::KIND_CMD_BYTE, c, stomp_pkg::ERR_NONE);
      if (cmd_pos < 4'd9 && c == pat) cmd_pos = cmd_pos + 4'd1;
      else cmd_pos = stomp_pkg::MISMATCH;
   endfunction

   function automatic void hdr_char(logic [7:0] d);
      string      pat;
      logic [63:0] v;
      pat = "content-length";
      if (ph == stomp_pkg::PH_KEY) begin
         put(stomp_pkg::KIND_KEY_BYTE, d, stomp_pkg::ERR_NONE);
         if (key_pos < 4'd14 && d == pat[key_pos]) key_pos = key_pos + 4'd1;
         else key_pos = stomp_pkg::MISMATCH;
         return;
      end
      put(stomp_pkg::KIND_VAL_BYTE, d, stomp_pkg::ERR_NONE);
      if (!len_cand) return;
      if (d < "0" || d > "9") begin
         len_bad = 1'b1;
         return;
      end
      len_digit = 1'b1;
      if (!len_over) begin
         v = 64'(len_acc) * 64'd10 + 64'(d - 8'd48);
         if (v > 64'(LEN_MAX)) len_over = 1'b1;
         else len_acc = v[23:0];
      end
   endfunction

   function automatic void hdr_content(logic [7:0] c);
      line_started = 1'b1;
      if (ph == stomp_pkg::PH_KEY && c == COLON) begin
         if (held_bs) bad_esc = 1'b1;
         held_bs = 1'b0;
         len_cand = (key_pos == 4'd14) && !len_seen;
         if (len_cand) len_acc = '0;
         ph = stomp_pkg::PH_VAL;
         return;
      end
      if (!esc_mode) begin
         hdr_char(c);
         return;
      end
      if (held_bs) begin
         held_bs = 1'b0;
         case (c)
            BSL: hdr_char(BSL);
            "n": hdr_char(LF);
            "r": hdr_char(CR);
            "c": hdr_char(COLON);
            default: bad_esc = 1'b1;
         endcase
         return;
      end
      if (c == BSL) held_bs = 1'b1;
      else hdr_char(c);
   endfunction

   function automatic void hdr_line_end();
      if (!line_started) begin
         put(stomp_pkg::KIND_LINE_END, 8'd0, stomp_pkg::ERR_NONE);
         line_clear();
         ph = stomp_pkg::PH_BODY;
         return;
      end
      if (ph == stomp_pkg::PH_KEY) begin
         flag_error(stomp_pkg::ERR_NO_COLON);
         return;
      end
      if (bad_esc || held_bs) begin
         flag_error(stomp_pkg::ERR_ESCAPE);
         return;
      end
      if (len_cand) begin
         if (len_bad || !len_digit) begin
            flag_error(stomp_pkg::ERR_LEN_BAD);
            return;
         end
         if (len_over || len_acc > lim_content) begin
            flag_error(stomp_pkg::ERR_LEN_LARGE);
            return;
         end
         len_seen = 1'b1;
         body_left = len_acc;
      end
      put(stomp_pkg::KIND_LINE_END, 8'd0, stomp_pkg::ERR_NONE);
      line_clear();
      ph = stomp_pkg::PH_KEY;
   endfunction

   function automatic void cmd_step(logic [7:0] b);
      if (b == NUL) begin
         flag_error(stomp_pkg::ERR_NUL_CMD);
         return;
      end
      if (b == LF) begin
         held_cr = 1'b0;
         put(stomp_pkg::KIND_CMD_END, 8'd0, stomp_pkg::ERR_NONE);
         esc_mode = !(cmd_pos == 4'd7 || cmd_pos == 4'd9);
         line_clear();
         ph = stomp_pkg::PH_KEY;
         return;
      end
      if (held_cr) begin
         held_cr = 1'b0;
         cmd_char(CR);
      end
      if (b == CR) held_cr = 1'b1;
      else cmd_char(b);
   endfunction

   function automatic void hdr_step(logic [7:0] b);
      if (b == NUL) begin
         flag_error(stomp_pkg::ERR_NUL_HDR);
         return;
      end
      if (b == LF) begin
         held_cr = 1'b0;
         hdr_line_end();
         return;
      end
      if (held_cr) begin
         held_cr = 1'b0;
         hdr_content(CR);
      end
      if (b == CR) held_cr = 1'b1;
      else hdr_content(b);
   endfunction

   function automatic void body_step(logic [7:0] b);
      if (len_seen && body_left > 0) begin
         put(stomp_pkg::KIND_BODY_BYTE, b, stomp_pkg::ERR_NONE);
         body_left = body_left - 24'd1;
      end else if (b == NUL) begin
         put(stomp_pkg::KIND_FRAME_END, 8'd0, stomp_pkg::ERR_NONE);
         frame_clear();
      end else if (len_seen) begin
         flag_error(stomp_pkg::ERR_FRAME);
      end else begin
         put(stomp_pkg::KIND_BODY_BYTE, b, stomp_pkg::ERR_NONE);
      end
   endfunction

   // Parse one wire byte and queue the results it causes.
   function automatic void deframe_byte(stomp_pkg::req_type t);
      logic [7:0]  b;
      int unsigned inc;
      logic        oversize;
      stomp_pkg::rsp_type r;
      b = t.in_byte;
      cur_last = t.chunk_last;
      byte_res_q.delete();
      if (discarding) begin
         if (cur_last) discarding = 1'b0;
         return;
      end
      inc = 0;
      oversize = 1'b0;
      if (ph != stomp_pkg::PH_IDLE) inc = 1;
      else if (b != LF && b != NUL && (held_cr || b != CR)) inc = held_cr ? 2 : 1;
      if (inc != 0) begin
         frame_cnt = frame_cnt + inc;
         if (frame_cnt > lim_frame) begin
            flag_error(stomp_pkg::ERR_FRAME);
            oversize = 1'b1;
         end
      end
      if (!oversize) begin
         case (ph)
            stomp_pkg::PH_IDLE: begin
               if (b == LF) begin
                  held_cr = 1'b0;
                  put(stomp_pkg::KIND_HEARTBEAT, 8'd0, stomp_pkg::ERR_NONE);
               end else if (b == NUL) begin
                  flag_error(held_cr ? stomp_pkg::ERR_NUL_CMD : stomp_pkg::ERR_NO_CMD);
               end else if (b == CR && !held_cr) begin
                  held_cr = 1'b1;
               end else begin
                  ph = stomp_pkg::PH_CMD;
                  cmd_pos = 4'd0;
                  cmd_step(b);
               end
            end
            stomp_pkg::PH_CMD: cmd_step(b);
            stomp_pkg::PH_KEY, stomp_pkg::PH_VAL: hdr_step(b);
            default: body_step(b);
         endcase
      end
      if (byte_res_q.size() > 0) begin
         r = byte_res_q.pop_back();
         r.last_result = 1'b1;
         byte_res_q.push_back(r);
      end
      foreach (byte_res_q[i]) parsed_q.push_back(byte_res_q[i]);
   endfunction

   // Driver: present queued bytes, hold a stalled transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_data);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (wire_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data <= wire_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stall, compare results, watchdog.
   always @(posedge clock) begin
      stomp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (parsed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind=%0d byte=%h code=%0d last=%0d",
                           rsp_data.kind, rsp_data.out_byte, rsp_data.error_code,
                           rsp_data.last_result);
            end else begin
               want = parsed_q.pop_front();
               if (want.kind == stomp_pkg::KIND_ERROR) errors_seen++;
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected kind=%0d byte=%h code=%0d last=%0d, %s",
                              want.kind, want.out_byte, want.error_code, want.last_result,
                              $sformatf("got kind=%0d byte=%h code=%0d last=%0d",
                                        rsp_data.kind, rsp_data.out_byte,
                                        rsp_data.error_code, rsp_data.last_result));
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", parsed_q.size());
            $display("stomp_frame_deframer test failed");
            $finish;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   function automatic void push_byte(logic [7:0] b, logic last);
      stomp_pkg::req_type t;
      t.in_byte = b;
      t.chunk_last = last;
      wire_q.push_back(t);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], $urandom_range(29) == 0);
   endfunction

   function automatic void push_eol();
      if ($urandom_range(1)) push_byte(CR, 1'b0);
      push_byte(LF, $urandom_range(19) == 0);
   endfunction

   // One random frame, mostly well formed, sometimes broken.
   task automatic gen_frame();
      string cmds[6];
      string keys[5];
      string vals[9];
      string cl_val;
      int    nh, cl_at, blen;
      bit    use_cl;
      cmds = '{"SEND", "CONNECT", "CONNECTED", "MESSAGE", "CONNEC", "S\rX"};
      keys = '{"dest", "id", "content-lengt", "k", "content-length"};
      vals = '{"q", "a\\nb", "\\c\\\\", "x\\ry", "b\\t", "a:b", "v\rw", "", "end\\"};
      if ($urandom_range(3) == 0) begin
         if ($urandom_range(1)) push_byte(CR, 1'b0);
         push_byte(LF, 1'b0);
      end
      push_text(cmds[$urandom_range(5)]);
      push_eol();
      blen = $urandom_range(0, 6);
      use_cl = 1'($urandom_range(1));
      nh = $urandom_range(0, 3);
      cl_at = use_cl ? $urandom_range(0, nh) : -1;
      for (int i = 0; i <= nh; i++) begin
         if (i == cl_at) begin
            case ($urandom_range(11))
               7: cl_val = "99999999";
               8: cl_val = "-1";
               9: cl_val = "16777215";
               10: cl_val = "";
               11: cl_val = "1a";
               default: cl_val = $sformatf("%0d", blen);
            endcase
            push_text({"content-length:", cl_val});
         end else if (i < nh) begin
            push_text({keys[$urandom_range(4)], ":",
                       ($urandom_range(3) == 0) ? vals[$urandom_range(8)] : "v1"});
         end else begin
            continue;
         end
         push_eol();
      end
      push_eol();
      for (int j = 0; j < blen; j++)
         push_byte(use_cl ? 8'($urandom_range(255)) : 8'($urandom_range(1, 255)),
                   $urandom_range(29) == 0);
      push_byte(NUL, 1'($urandom_range(1)));
      // line noise
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 4))
            push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic drain();
      do @(posedge clock);
      while (wire_q.size() > 0 || req_valid || parsed_q.size() > 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == stomp_pkg::CSR_MAX_CONTENT_LENGTH) lim_content = val;
      else lim_frame = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(int s_idle, int r_idle, int n);
      send_idle = s_idle;
      recv_idle = r_idle;
      while (wire_q.size() < n) gen_frame();
      drain();
   endtask

   initial begin
      lim_content = stomp_pkg::MAX_LEN_RESET;
      lim_frame = stomp_pkg::MAX_LEN_RESET;
      discarding = 1'b0;
      frame_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: heartbeats, lone NUL, CR NUL, escape, NUL in header, no colon
      send_idle = 38;
      recv_idle = 80;
      push_byte(LF, 1'b0);
      push_byte(CR, 1'b0);
      push_byte(LF, 1'b0);
      push_byte(NUL, 1'b1);
      push_byte(CR, 1'b0);
      push_byte(NUL, 1'b1);
      push_text("A\r\nk\\:x");
      push_byte(LF, 1'b1);
      push_text("B\nk");
      push_byte(NUL, 1'b1);
      push_text("C\nxy");
      push_byte(LF, 1'b1);
      push_byte(8'hFF, 1'b1);
      drain();

      run_phase(38, 80, 150);
      write_reg(stomp_pkg::CSR_MAX_CONTENT_LENGTH, 24'd5);
      write_reg(stomp_pkg::CSR_MAX_FRAME_BYTES, 24'd60);
      run_phase(80, 38, 150);
      write_reg(stomp_pkg::CSR_MAX_CONTENT_LENGTH, 24'd0);
      write_reg(stomp_pkg::CSR_MAX_FRAME_BYTES, LEN_MAX);
      run_phase(0, 0, 150);
      write_reg(stomp_pkg::CSR_MAX_CONTENT_LENGTH, LEN_MAX);
      write_reg(stomp_pkg::CSR_MAX_FRAME_BYTES, 24'd25);
      run_phase(0, 0, 150);
      write_reg(stomp_pkg::CSR_MAX_FRAME_BYTES, 24'd1);
      run_phase(0, 0, 30);

      $display("sent %0d wire bytes over five limit settings and three idling mixes,",
               bytes_sent);
      $display("checked %0d results, %0d of them error reports", results_seen, errors_seen);
      if (mismatches == 0 && parsed_q.size() == 0) begin
         $display("stomp_frame_deframer test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, parsed_q.size());
         $display("stomp_frame_deframer test failed");
      end
      $finish;
   end

endmodule

// ----- stomp_frame_deframer.f -----
src/stomp_pkg.sv
src/stomp_frame_deframer.sv
src/stomp_checker.sv
dv/testbench.sv
